// ===== rtl/v4n_pkg.sv =====
`default_nettype none

package v4n_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UNIT_W    = 18;
    // quotient bits 16..0, the magnitude never exceeds 1.0
    localparam int QUO_BITS  = 17;
    localparam int LANES     = 4;

endpackage

`default_nettype wire

// ===== rtl/v4n_square.sv =====
`default_nettype none

module v4n_square #(
    parameter int CW = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [4*CW-1:0]     comp,
    output logic                     out_valid,
    output logic [2*CW:0]            sum,
    output logic [4*CW-1:0]          mag,
    output logic [3:0]               neg,
    output logic                     zero
);
    import v4n_pkg::*;

    localparam int LO_W  = (CW + 1) / 2;
    localparam int HI_W  = CW - LO_W;
    localparam int SQ_W  = 2 * CW;
    localparam int SUM_W = 2 * CW + 1;

    logic                     v1_reg, v2_reg, v3_reg;
    logic [4*CW-1:0]          mag_next, mag1_reg, mag2_reg, mag3_reg;
    logic [3:0]               neg_next, neg1_reg, neg2_reg, neg3_reg;
    logic                     zero1_reg, zero2_reg, zero3_reg;
    logic [2*LO_W-1:0]        pl_reg [0:LANES-1];
    logic [HI_W+LO_W-1:0]     pm_reg [0:LANES-1];
    logic [2*HI_W-1:0]        ph_reg [0:LANES-1];
    logic [SQ_W-1:0]          sq_reg [0:LANES-1];
    logic [SUM_W-1:0]         sum_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [CW-1:0]   c;
        logic [CW-1:0]   m;
        logic [LO_W-1:0] lo;
        logic [HI_W-1:0] hi;

        assign c  = comp[l*CW +: CW];
        assign m  = c[CW-1] ? (~c + CW'(1)) : c;
        assign lo = m[LO_W-1:0];
        assign hi = m[CW-1:LO_W];
        assign mag_next[l*CW +: CW] = m;
        assign neg_next[l] = c[CW-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pl_reg[l] <= (2*LO_W)'(lo) * (2*LO_W)'(lo);
                pm_reg[l] <= (HI_W+LO_W)'(hi) * (HI_W+LO_W)'(lo);
                ph_reg[l] <= (2*HI_W)'(hi) * (2*HI_W)'(hi);
                sq_reg[l] <= (SQ_W'(ph_reg[l]) << (2*LO_W))
                           + (SQ_W'(pm_reg[l]) << (LO_W+1))
                           + SQ_W'(pl_reg[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag_next;
            neg1_reg  <= neg_next;
            zero1_reg <= (comp == '0);
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                       + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
        end
    end

    assign out_valid = v3_reg;
    assign sum       = sum_reg;
    assign mag       = mag3_reg;
    assign neg       = neg3_reg;
    assign zero      = zero3_reg;

endmodule

`default_nettype wire

// ===== rtl/v4n_sqrt.sv =====
`default_nettype none

module v4n_sqrt #(
    parameter int CW     = 32,
    parameter int SIDE_W = 133
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [2*CW:0]     s,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [CW:0]            len,
    output logic [SIDE_W-1:0]      side_out
);
    localparam int RW = 2 * CW + 1;
    localparam int TW = CW + 1;

    logic              v_reg    [0:CW];
    logic [RW-1:0]     rem_reg  [0:CW];
    logic [TW-1:0]     root_reg [0:CW];
    logic [SIDE_W-1:0] side_reg [0:CW];
    logic              vr_reg;
    logic [TW-1:0]     len_reg;
    logic [SIDE_W-1:0] sider_reg;

    // one root bit per stage, MSB first; rem tracks s - root^2
    for (genvar i = 0; i <= CW; i++) begin : g_bit
        localparam int B = CW - i;
        logic              v_in;
        logic [RW-1:0]     rem_in;
        logic [TW-1:0]     root_in;
        logic [SIDE_W-1:0] sd_in;
        logic [RW-1:0]     trial;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = s;
            assign root_in = '0;
            assign sd_in   = side_in;
        end
        else begin : g_rest
            assign v_in    = v_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign sd_in   = side_reg[i-1];
        end

        // (root + 2^B)^2 - root^2
        assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= sd_in;
                if (rem_in >= trial)
                begin
                    rem_reg[i]  <= rem_in - trial;
                    root_reg[i] <= root_in | (TW'(1) << B);
                end
                else
                begin
                    rem_reg[i]  <= rem_in;
                    root_reg[i] <= root_in;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr_reg <= 1'b0;
        else if (en)
            vr_reg <= v_reg[CW];
    end

    // round to nearest, ties up: bump when remainder exceeds root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg   <= root_reg[CW] + TW'(rem_reg[CW] > RW'(root_reg[CW]));
            sider_reg <= side_reg[CW];
        end
    end

    assign out_valid = vr_reg;
    assign len       = len_reg;
    assign side_out  = sider_reg;

endmodule

`default_nettype wire

// ===== rtl/v4n_div.sv =====
`default_nettype none

module v4n_div #(
    parameter int CW = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [CW:0]                   len_in,
    input  wire logic [4*CW-1:0]               mag,
    input  wire logic [3:0]                    neg,
    input  wire logic                          zero_in,
    output logic                               out_valid,
    output logic [CW:0]                        len_out,
    output logic                               zero_out,
    output logic [4*v4n_pkg::UNIT_W-1:0]       unit
);
    import v4n_pkg::*;

    localparam int NW = CW + FRAC_BITS + 1;
    localparam int TW = CW + 1;

    logic              vp_reg;
    logic [TW-1:0]     lenp_reg;
    logic [3:0]        negp_reg;
    logic              zerop_reg;
    logic [NW-1:0]     nump_reg [0:LANES-1];

    logic              v_reg    [0:QUO_BITS-1];
    logic [TW-1:0]     len_reg  [0:QUO_BITS-1];
    logic [3:0]        neg_reg  [0:QUO_BITS-1];
    logic              zero_reg [0:QUO_BITS-1];
    logic [NW-1:0]     rem_reg  [0:QUO_BITS-1][0:LANES-1];
    logic [QUO_BITS-1:0] q_reg  [0:QUO_BITS-1][0:LANES-1];

    logic              vf_reg;
    logic [TW-1:0]     lenf_reg;
    logic              zerof_reg;
    logic [UNIT_W-1:0] unit_reg [0:LANES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg <= in_valid;
            vf_reg <= v_reg[QUO_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lenp_reg  <= len_in;
            negp_reg  <= neg;
            zerop_reg <= zero_in;
            lenf_reg  <= len_reg[QUO_BITS-1];
            zerof_reg <= zero_reg[QUO_BITS-1];
        end
    end

    // numerator with half the divisor added for round to nearest
    for (genvar l = 0; l < LANES; l++) begin : g_num
        always_ff @(posedge clk)
        begin
            if (en)
                nump_reg[l] <= (NW'(mag[l*CW +: CW]) << FRAC_BITS) + NW'(len_in >> 1);
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        localparam int J = QUO_BITS - 1 - k;
        logic          v_in;
        logic [TW-1:0] len_s;
        logic [3:0]    neg_s;
        logic          zero_s;
        logic [NW-1:0] dv;

        if (k == 0) begin : g_first
            assign v_in   = vp_reg;
            assign len_s  = lenp_reg;
            assign neg_s  = negp_reg;
            assign zero_s = zerop_reg;
        end
        else begin : g_rest
            assign v_in   = v_reg[k-1];
            assign len_s  = len_reg[k-1];
            assign neg_s  = neg_reg[k-1];
            assign zero_s = zero_reg[k-1];
        end

        assign dv = NW'(len_s) << J;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[k]  <= len_s;
                neg_reg[k]  <= neg_s;
                zero_reg[k] <= zero_s;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [NW-1:0]       r_in;
            logic [QUO_BITS-1:0] q_in;

            if (k == 0) begin : g_first
                assign r_in = nump_reg[l];
                assign q_in = '0;
            end
            else begin : g_rest
                assign r_in = rem_reg[k-1][l];
                assign q_in = q_reg[k-1][l];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (r_in >= dv)
                    begin
                        rem_reg[k][l] <= r_in - dv;
                        q_reg[k][l]   <= q_in | (QUO_BITS'(1) << J);
                    end
                    else
                    begin
                        rem_reg[k][l] <= r_in;
                        q_reg[k][l]   <= q_in;
                    end
                end
            end
        end
    end

    // zero vector divides by zero above; its quotient is discarded here
    for (genvar l = 0; l < LANES; l++) begin : g_out
        logic [UNIT_W-1:0] uq;

        assign uq = UNIT_W'(q_reg[QUO_BITS-1][l]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zero_reg[QUO_BITS-1])
                    unit_reg[l] <= '0;
                else if (neg_reg[QUO_BITS-1][l])
                    unit_reg[l] <= ~uq + UNIT_W'(1);
                else
                    unit_reg[l] <= uq;
            end
        end

        assign unit[l*UNIT_W +: UNIT_W] = unit_reg[l];
    end

    assign out_valid = vf_reg;
    assign len_out   = lenf_reg;
    assign zero_out  = zerof_reg;

endmodule

`default_nettype wire

// ===== rtl/vector4_normalize.sv =====
// Channel  Dir  Beat fields (lowest bit up)
// s_*      in   tdata: comp_x, comp_y, comp_z, comp_w (COMPONENT_WIDTH each, signed)
// m_*      out  tdata: length (COMPONENT_WIDTH+1), unit_x..unit_w (18 each); tuser: zero_vector
//
// One beat per cycle sustained while m_ does not stall. The stages in order are squares,
// bitwise root, 17-step divide and output register.
// Reset clears only valid bits; the pipeline is empty afterwards.
// A stall on m_ fills a one-beat skid; the pipeline then holds and s_tready drops.
`default_nettype none

module vector4_normalize #(
    parameter int COMPONENT_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // comp_x, comp_y, comp_z, comp_w
    input  wire logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // length, unit_x, unit_y, unit_z, unit_w
    output logic [((COMPONENT_WIDTH+1+4*v4n_pkg::UNIT_W+7)/8)*8-1:0] m_tdata,
    // zero_vector
    output logic                       m_tuser
);
    import v4n_pkg::*;

    localparam int CW      = COMPONENT_WIDTH;
    localparam int SIDE_W  = 4 * CW + 4 + 1;
    localparam int ODATA_W = CW + 1 + 4 * UNIT_W;
    localparam int OBUS_W  = ((ODATA_W + 7) / 8) * 8;

    logic                en;
    logic                sq_valid;
    logic [2*CW:0]       sq_sum;
    logic [4*CW-1:0]     sq_mag;
    logic [3:0]          sq_neg;
    logic                sq_zero;
    logic                rt_valid;
    logic [CW:0]         rt_len;
    logic [SIDE_W-1:0]   rt_side;
    logic                p_valid;
    logic [CW:0]         p_len;
    logic                p_zero;
    logic [4*UNIT_W-1:0] p_unit;
    logic [ODATA_W-1:0]  p_data;

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [ODATA_W-1:0]  out_data_reg, out_data_next;
    logic                out_zero_reg, out_zero_next;
    logic [ODATA_W-1:0]  skid_data_reg;
    logic                skid_zero_reg;
    logic                skid_load;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    v4n_square #(.CW(CW)) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .comp      (s_tdata[4*CW-1:0]),
        .out_valid (sq_valid),
        .sum       (sq_sum),
        .mag       (sq_mag),
        .neg       (sq_neg),
        .zero      (sq_zero)
    );

    v4n_sqrt #(.CW(CW), .SIDE_W(SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .s         (sq_sum),
        .side_in   ({sq_zero, sq_neg, sq_mag}),
        .out_valid (rt_valid),
        .len       (rt_len),
        .side_out  (rt_side)
    );

    v4n_div #(.CW(CW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .len_in    (rt_len),
        .mag       (rt_side[4*CW-1:0]),
        .neg       (rt_side[4*CW+3:4*CW]),
        .zero_in   (rt_side[SIDE_W-1]),
        .out_valid (p_valid),
        .len_out   (p_len),
        .zero_out  (p_zero),
        .unit      (p_unit)
    );

    assign p_data = {p_unit, p_len};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_zero_next   = out_zero_reg;
        skid_valid_next = skid_valid_reg;
        skid_load       = 1'b0;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_zero_next   = skid_zero_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = p_valid;
                out_data_next  = p_data;
                out_zero_next  = p_zero;
            end
        end
        else if (p_valid && en)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_zero_reg <= out_zero_next;
        if (skid_load)
        begin
            skid_data_reg <= p_data;
            skid_zero_reg <= p_zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OBUS_W'(out_data_reg);
    assign m_tuser  = out_zero_reg;

endmodule

`default_nettype wire

// ===== rtl/v4n_checker.sv =====
`default_nettype none

module v4n_checker #(
    parameter int COMPONENT_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [((COMPONENT_WIDTH+1+4*v4n_pkg::UNIT_W+7)/8)*8-1:0] m_tdata,
    input  wire logic                  m_tuser
);
    import v4n_pkg::*;

    localparam int LW = COMPONENT_WIDTH + 1;

    logic [LW-1:0]     len_f;
    logic [UNIT_W-1:0] ux, uy;
    logic              ux_ok, uy_ok;

    assign len_f = m_tdata[LW-1:0];
    assign ux    = m_tdata[LW +: UNIT_W];
    assign uy    = m_tdata[LW+UNIT_W +: UNIT_W];
    // legal range is -1.0 .. +1.0
    assign ux_ok = (ux[17:16] == 2'b00) || (ux[17:16] == 2'b11)
                || (ux[17:16] == 2'b01 && ux[15:0] == 16'h0000);
    assign uy_ok = (uy[17:16] == 2'b00) || (uy[17:16] == 2'b11)
                || (uy[17:16] == 2'b01 && uy[15:0] == 16'h0000);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped during stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("m beat changed during stall");

    a_zero_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero vector beat carries nonzero data");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> len_f != '0)
        else $error("nonzero vector with zero length");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ux_ok && uy_ok)
        else $error("unit component beyond 1.0");

endmodule

bind vector4_normalize v4n_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_v4n_checker (.*);

`default_nettype wire
